// File: rtl/mhpq_pkg.sv
package mhpq_pkg;

  localparam int unsigned DEF_CAPACITY   = 256;
  localparam int unsigned DEF_DATA_WIDTH = 32;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W = 9;

  typedef enum logic [0:0] {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_EX_LOAD,
    S_DN_RD,
    S_DN_CMP,
    S_FIN
  } state_t;

  typedef struct packed {
    op_t                        operation;
    logic signed [VALUE_W-1:0]  in_value;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  top_value;
    status_t                    status;
    logic [COUNT_W-1:0]         entry_count;
  } out_word_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

// File: rtl/mhpq_mem.sv
module mhpq_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 8
) (
  input  logic                clk,
  input  mhpq_pkg::mem_ctl_t  ctl,
  input  logic [AW-1:0]       rd_addr_a,
  input  logic [AW-1:0]       rd_addr_b,
  output logic [WIDTH-1:0]    rd_data_a,
  output logic [WIDTH-1:0]    rd_data_b,
  input  logic [AW-1:0]       wr_addr,
  input  logic [WIDTH-1:0]    wr_data
);
  import mhpq_pkg::*;

  logic [WIDTH-1:0] store [DEPTH];

  // Two registered read ports and one write port; contents are undefined until written.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      store[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_a <= store[rd_addr_a];
      rd_data_b <= store[rd_addr_b];
    end
  end

endmodule

// File: rtl/max_heap_priority_queue_top.sv
// Binary max-heap priority queue of signed values, held in one memory of CAPACITY
// entries with two registered read ports and one write port. Each input word is an
// insert or an extract-maximum and yields exactly one result word carrying the
// extracted value (zero unless an extract succeeds), a status code and the entry
// count after the operation. Words are handled one at a time; the next word can be
// taken in the cycle after the result of the last one is loaded into the output
// register. An insert lets the new value climb level by level, possibly up to the
// root, and each level costs one parent read and one compare with write-back. An
// extract lets the moved entry descend level by level toward a leaf until a compare
// stops it: at each level both children are read together, then compared and
// written back. An insert into a full heap and an extract from an empty heap leave
// the heap unchanged. The result sits in an output register, so the next word is
// taken while an earlier result still waits to be collected; only a finished result
// that cannot be handed over holds the sequencer.
module max_heap_priority_queue_top #(
  parameter int unsigned CAPACITY   = mhpq_pkg::DEF_CAPACITY,
  parameter int unsigned DATA_WIDTH = mhpq_pkg::DEF_DATA_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mhpq_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mhpq_pkg::out_word_t  out_data
);
  import mhpq_pkg::*;

  // Address width, child index width (holds 2*i + 2) and count width.
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned IW = AW + 2;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned DW = DATA_WIDTH;

  state_t state_r, state_nxt;

  logic [CW-1:0]      count_r, count_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [DW-1:0]      val_r, val_nxt;
  logic [VALUE_W-1:0] top_r, top_nxt;
  status_t            status_r, status_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_r, out_nxt;

  mem_ctl_t           mem_ctl;
  logic [AW-1:0]      rd_addr_a, rd_addr_b, wr_addr;
  logic [DW-1:0]      rd_data_a, rd_data_b, wr_data;

  logic               accept;
  logic               full, empty;
  logic [IW-1:0]      count_ext, left_idx, right_idx;
  logic               left_in, right_in;
  logic [AW-1:0]      idx_m1, parent_idx;
  logic [CW-1:0]      last_idx;
  logic [DW-1:0]      in_val_ext;
  logic               pick_right;
  logic [DW-1:0]      child_val;
  logic [AW-1:0]      child_addr;
  logic [CW+COUNT_W-1:0] count_wide;

  // Helper values for the heap arithmetic.
  assign accept     = in_valid && in_ready;
  assign full       = (count_r == CW'(CAPACITY));
  assign empty      = (count_r == '0);
  assign count_ext  = {{(IW-CW){1'b0}}, count_r};
  assign left_idx   = {1'b0, idx_r, 1'b1};
  assign right_idx  = left_idx + IW'(1);
  assign left_in    = (left_idx < count_ext);
  assign right_in   = (right_idx < count_ext);
  assign idx_m1     = idx_r - AW'(1);
  assign parent_idx = idx_m1 >> 1;
  assign last_idx   = count_r - CW'(1);
  assign count_wide = {{COUNT_W{1'b0}}, count_r};

  // The input value is brought to DATA_WIDTH bits by sign extension or truncation.
  logic [VALUE_W+64-1:0] in_wide;
  assign in_wide    = {{64{in_data.in_value[VALUE_W-1]}}, in_data.in_value};
  assign in_val_ext = in_wide[DW-1:0];

  // Sift-down picks the right child when it exists and is not smaller than the left.
  assign pick_right = right_in && !($signed(rd_data_a) > $signed(rd_data_b));
  assign child_val  = pick_right ? rd_data_b : rd_data_a;
  assign child_addr = pick_right ? right_idx[AW-1:0] : left_idx[AW-1:0];

  // Extracted root widened back to the 32-bit result field.
  logic [DW+VALUE_W-1:0] root_wide;
  assign root_wide = {{VALUE_W{rd_data_a[DW-1]}}, rd_data_a};

  mhpq_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (DW),
    .AW    (AW)
  ) u_mem (
    .clk       (clk),
    .ctl       (mem_ctl),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.operation == OP_INSERT) begin
            state_nxt = full ? S_FIN : S_UP_RD;
          end else begin
            state_nxt = empty ? S_FIN : S_EX_LOAD;
          end
        end
      end
      S_UP_RD: begin
        state_nxt = (idx_r == '0) ? S_FIN : S_UP_CMP;
      end
      S_UP_CMP: begin
        state_nxt = ($signed(val_r) > $signed(rd_data_a)) ? S_UP_RD : S_FIN;
      end
      S_EX_LOAD: begin
        state_nxt = empty ? S_FIN : S_DN_RD;
      end
      S_DN_RD: begin
        state_nxt = left_in ? S_DN_CMP : S_FIN;
      end
      S_DN_CMP: begin
        state_nxt = ($signed(val_r) > $signed(child_val)) ? S_FIN : S_DN_RD;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory accesses and the working registers.
  always_comb begin
    in_ready      = (state_r == S_IDLE);
    mem_ctl       = '0;
    rd_addr_a     = '0;
    rd_addr_b     = '0;
    wr_addr       = idx_r;
    wr_data       = val_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    top_nxt       = top_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          top_nxt    = '0;
          status_nxt = STAT_OK;
          if (in_data.operation == OP_INSERT) begin
            if (full) begin
              status_nxt = STAT_FULL;
            end else begin
              // The new value enters as a hole at the end of the heap.
              val_nxt   = in_val_ext;
              idx_nxt   = count_r[AW-1:0];
              count_nxt = count_r + CW'(1);
            end
          end else begin
            if (empty) begin
              status_nxt = STAT_EMPTY;
            end else begin
              // Root and last entry are fetched together.
              mem_ctl.rd_en = 1'b1;
              rd_addr_a     = '0;
              rd_addr_b     = last_idx[AW-1:0];
              count_nxt     = last_idx;
            end
          end
        end
      end
      S_UP_RD: begin
        if (idx_r == '0) begin
          mem_ctl.wr_en = 1'b1;
        end else begin
          mem_ctl.rd_en = 1'b1;
          rd_addr_a     = parent_idx;
        end
      end
      S_UP_CMP: begin
        mem_ctl.wr_en = 1'b1;
        if ($signed(val_r) > $signed(rd_data_a)) begin
          // The parent moves down into the hole, and the hole climbs.
          wr_data = rd_data_a;
          idx_nxt = parent_idx;
        end
      end
      S_EX_LOAD: begin
        top_nxt = root_wide[VALUE_W-1:0];
        val_nxt = rd_data_b;
        idx_nxt = '0;
      end
      S_DN_RD: begin
        if (left_in) begin
          mem_ctl.rd_en = 1'b1;
          rd_addr_a     = left_idx[AW-1:0];
          rd_addr_b     = right_in ? right_idx[AW-1:0] : left_idx[AW-1:0];
        end else begin
          mem_ctl.wr_en = 1'b1;
        end
      end
      S_DN_CMP: begin
        mem_ctl.wr_en = 1'b1;
        if (!($signed(val_r) > $signed(child_val))) begin
          // The larger child moves up into the hole, and the hole descends.
          wr_data = child_val;
          idx_nxt = child_addr;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt       = 1'b1;
          out_nxt.top_value   = top_r;
          out_nxt.status      = status_r;
          out_nxt.entry_count = count_wide[COUNT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    val_r    <= val_nxt;
    top_r    <= top_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: tb/max_heap_priority_queue_top_test.sv
module max_heap_priority_queue_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mhpq_pkg::*;

  // The heap ledger keeps a shadow copy of the heap. Every accepted input word
  // is applied to it at once, and the result word that the block should return
  // is queued. Result words leave the block in input order, so each one is
  // compared with the oldest queued entry.
  class heap_ledger;
    logic signed [VALUE_W-1:0] shadow_heap [DEF_CAPACITY];
    int unsigned               held;
    out_word_t                 awaited_results [$];
    int unsigned               fail_count;

    function new();
      held       = 0;
      fail_count = 0;
    endfunction

    // Applies one operation to the shadow heap and returns the result word.
    function out_word_t apply_heap_op(in_word_t w);
      out_word_t                 r;
      int unsigned               pos;
      int unsigned               parent;
      int unsigned               left;
      int unsigned               pick;
      logic signed [VALUE_W-1:0] tmp;
      r.top_value = '0;
      r.status    = STAT_OK;
      if (w.operation == OP_INSERT) begin
        if (held >= DEF_CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          pos              = held;
          shadow_heap[pos] = w.in_value;
          held++;
          // Climb while strictly greater than the parent.
          while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (!(shadow_heap[pos] > shadow_heap[parent])) break;
            tmp                 = shadow_heap[pos];
            shadow_heap[pos]    = shadow_heap[parent];
            shadow_heap[parent] = tmp;
            pos                 = parent;
          end
        end
      end else begin
        if (held == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.top_value    = shadow_heap[0];
          held--;
          shadow_heap[0] = shadow_heap[held];
          pos            = 0;
          // Descend toward the larger child; ties go right, and the entry
          // carries on past a child equal to it.
          while (2 * pos + 1 < held) begin
            left = 2 * pos + 1;
            pick = left;
            if (left + 1 < held && !(shadow_heap[left] > shadow_heap[left + 1]))
              pick = left + 1;
            if (shadow_heap[pos] > shadow_heap[pick]) break;
            tmp               = shadow_heap[pos];
            shadow_heap[pos]  = shadow_heap[pick];
            shadow_heap[pick] = tmp;
            pos               = pick;
          end
        end
      end
      r.entry_count = COUNT_W'(held);
      return r;
    endfunction

    function void note_word(in_word_t w);
      out_word_t r;
      r = apply_heap_op(w);
      awaited_results.insert(awaited_results.size(), r);
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (awaited_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result word: top %0d status %0d count %0d",
                   got.top_value, got.status, got.entry_count);
        return;
      end
      want = awaited_results.pop_front();
      if (got.top_value !== want.top_value || got.status !== want.status ||
          got.entry_count !== want.entry_count) begin
        fail_count++;
        if (fail_count <= 10)
          $display({"result mismatch: expected top %0d status %0d count %0d,",
                    " got top %0d status %0d count %0d"},
                   want.top_value, want.status, want.entry_count,
                   got.top_value, got.status, got.entry_count);
      end
    endfunction
  endclass

  // The quiet span that a correct word can cause (sender gap, sift time and
  // receiver stall together) lies far below this limit, which leaves a wide
  // margin.
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 40;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  heap_ledger  ledger;
  int unsigned planned;
  int unsigned quiet_cycles;
  bit          calm_tail;

  max_heap_priority_queue_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5ns clk = ~clk;

  // One value in eight comes from a narrow band so that equal keys turn up
  // often, some are special words such as the extremes of the signed range,
  // and most are plain random words, which exercise every bit.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = $signed($urandom_range(0, 8)) - 4;
      1: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh7FFF_FFFF;
          1: v = 32'sh8000_0000;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Presents one word and returns at the edge where it is taken. Before the
  // word the sender may fall idle for a burst; valid only drops for such a
  // burst, so back-to-back words keep it high throughout.
  task automatic issue(input op_t op, input logic signed [VALUE_W-1:0] value);
    in_word_t w;
    w.operation = op;
    w.in_value  = value;
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    ledger.note_word(w);
    if (op == OP_INSERT && planned < DEF_CAPACITY) planned++;
    else if (op == OP_EXTRACT && planned > 0) planned--;
  endtask

  // The receiver takes words for runs of random length and stalls for short
  // bursts in between, except in the calm tail of the run.
  initial begin : ready_driver
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!calm_tail && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
  end

  // Every result word handed over is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) ledger.check_word(out_data);
  end

  // The watchdog ends a run in which neither channel has moved a word for
  // far too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic signed [VALUE_W-1:0] directed_values [11];
    int unsigned               full_hits;
    int unsigned               empty_hits;
    ledger       = new();
    planned      = 0;
    calm_tail    = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: the extremes, alternating bit patterns and several
    // equal keys, including a repeated maximum. Draining the lot shows the
    // ordering, and an extract at either end meets an empty heap.
    directed_values = '{32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1, 32'sd1,
                        32'sh7FFF_FFFF, 32'sd5, 32'sd5, 32'sd5, 32'sh5555_5555,
                        32'shAAAA_AAAA};
    issue(OP_EXTRACT, 32'sh7FFF_FFFF);
    foreach (directed_values[i]) issue(OP_INSERT, directed_values[i]);
    foreach (directed_values[i]) issue(OP_EXTRACT, ~directed_values[i]);
    issue(OP_EXTRACT, '0);

    // A short mixed stretch with inserts slightly ahead.
    repeat (20) issue(($urandom_range(0, 99) < 60) ? OP_INSERT : OP_EXTRACT, pick_value());

    // Fill the heap to capacity, then keep pushing against the full heap
    // with the odd extract mixed in so that it refills.
    full_hits = 0;
    while (full_hits < 6) begin
      if (planned == DEF_CAPACITY) begin
        if ($urandom_range(0, 9) < 7) begin
          full_hits++;
          issue(OP_INSERT, pick_value());
        end else begin
          issue(OP_EXTRACT, pick_value());
        end
      end else begin
        issue(($urandom_range(0, 99) < 96) ? OP_INSERT : OP_EXTRACT, pick_value());
      end
    end

    // Drain it again, hitting the empty heap several times. The last part of
    // the drain runs with no idling on either side.
    empty_hits = 0;
    while (empty_hits < 6) begin
      if (planned < 40) calm_tail = 1'b1;
      if (planned == 0) begin
        if ($urandom_range(0, 9) < 6) begin
          empty_hits++;
          issue(OP_EXTRACT, pick_value());
        end else begin
          issue(OP_INSERT, pick_value());
        end
      end else begin
        issue(($urandom_range(0, 99) < 96) ? OP_EXTRACT : OP_INSERT, pick_value());
      end
    end
    in_valid <= 1'b0;

    // Wait for the outstanding results, then a little longer to catch any
    // stray word the block might still produce.
    while (ledger.awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (ledger.fail_count == 0 && ledger.awaited_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: max_heap_priority_queue_top.f
rtl/mhpq_pkg.sv
rtl/mhpq_mem.sv
rtl/max_heap_priority_queue_top.sv
tb/max_heap_priority_queue_top_test.sv
